// ===== rtl/ccld_pkg.sv =====
// Shared types, constants and the byte CRC function of the checked line deframer.
`default_nettype none

package ccld_pkg;

  // Line length, header included, at which a line overflows; the longest line held is one byte less.
  localparam int LINE_BYTES = 512;
  localparam int CNT_W      = $clog2(LINE_BYTES);
  // Width used to form the payload length before it is cut to the port width.
  localparam int LEN_W      = 9;
  localparam int EXT_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam int WIN_LEN    = 5;
  localparam int MIN_LINE   = 8;
  // Header byte plus the five-byte trailer window.
  localparam int TRAILER    = WIN_LEN + 1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Depth of the queue between the classifier and the line engine.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_CRC_BAD   = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic {
    TK_DATA = 1'b0,
    TK_EOL  = 1'b1
  } tok_kind_t;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  data;
    logic        is_dollar;
    logic        is_star;
    logic        hex_ok;
    logic [3:0]  hex_val;
  } tok_t;

  // CRC-16-CCITT, MSB first, one byte.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ccld_front.sv =====
// Front end: accepts received bytes, drops carriage returns and classifies the rest.
`default_nettype none

module ccld_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_rx_byte,
  output logic               tok_valid,
  output ccld_pkg::tok_t     tok,
  input  wire logic          tok_ready
);

  logic           tok_valid_r;
  logic           tok_valid_nxt;
  ccld_pkg::tok_t tok_r;
  ccld_pkg::tok_t tok_nxt;
  logic           take;
  logic           push;

  assign push     = tok_valid_r && tok_ready;
  assign in_ready = !tok_valid_r || tok_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    tok_nxt           = '0;
    tok_nxt.kind      = (in_rx_byte == ccld_pkg::CH_LF) ? ccld_pkg::TK_EOL : ccld_pkg::TK_DATA;
    tok_nxt.data      = in_rx_byte;
    tok_nxt.is_dollar = (in_rx_byte == ccld_pkg::CH_DOLLAR);
    tok_nxt.is_star   = (in_rx_byte == ccld_pkg::CH_STAR);
    tok_nxt.hex_ok    = 1'b1;
    if (in_rx_byte >= 8'h30 && in_rx_byte <= 8'h39) begin
      tok_nxt.hex_val = in_rx_byte[3:0];
    end else if ((in_rx_byte >= 8'h41 && in_rx_byte <= 8'h46) ||
                 (in_rx_byte >= 8'h61 && in_rx_byte <= 8'h66)) begin
      tok_nxt.hex_val = in_rx_byte[3:0] + 4'd9;
    end else begin
      tok_nxt.hex_ok  = 1'b0;
      tok_nxt.hex_val = 4'h0;
    end
  end

  // A carriage return is accepted and simply not passed on.
  always_comb begin
    tok_valid_nxt = tok_valid_r;
    if (take && in_rx_byte != ccld_pkg::CH_CR) begin
      tok_valid_nxt = 1'b1;
    end else if (push) begin
      tok_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_valid = tok_valid_r;
  assign tok       = tok_r;

endmodule

`default_nettype wire

// ===== rtl/ccld_queue.sv =====
// Short queue of classified bytes between the front end and the line engine.
`default_nettype none

module ccld_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire ccld_pkg::tok_t push_tok,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output ccld_pkg::tok_t     pop_tok
);

  ccld_pkg::tok_t                 slot_r [ccld_pkg::Q_DEPTH];
  logic [ccld_pkg::Q_PTR_W-1:0]   wr_ptr_r;
  logic [ccld_pkg::Q_PTR_W-1:0]   wr_ptr_nxt;
  logic [ccld_pkg::Q_PTR_W-1:0]   rd_ptr_r;
  logic [ccld_pkg::Q_PTR_W-1:0]   rd_ptr_nxt;
  logic [ccld_pkg::Q_CNT_W-1:0]   count_r;
  logic [ccld_pkg::Q_CNT_W-1:0]   count_nxt;
  logic                           push;
  logic                           pop;

  localparam logic [ccld_pkg::Q_PTR_W-1:0] PTR_LAST = ccld_pkg::Q_PTR_W'(ccld_pkg::Q_DEPTH - 1);
  localparam logic [ccld_pkg::Q_CNT_W-1:0] CNT_FULL = ccld_pkg::Q_CNT_W'(ccld_pkg::Q_DEPTH);

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_tok    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue fill count above depth");

  a_cnt_up : assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on push");

  a_ptr_gap : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue empty but pointers differ");

endmodule

`default_nettype wire

// ===== rtl/ccld_back.sv =====
// Line engine: trailer window, running CRC, end-of-line checks and the result register.
`default_nettype none

module ccld_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          tok_valid,
  output logic               tok_ready,
  input  wire ccld_pkg::tok_t tok,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_is_end,
  output logic [7:0]         out_data_byte,
  output logic [1:0]         out_status,
  output logic [8:0]         out_payload_length
);

  localparam logic [ccld_pkg::CNT_W-1:0] CNT_MAX  = ccld_pkg::CNT_W'(ccld_pkg::LINE_BYTES - 1);
  localparam logic [ccld_pkg::CNT_W-1:0] CNT_MIN  = ccld_pkg::CNT_W'(ccld_pkg::MIN_LINE);
  localparam logic [ccld_pkg::CNT_W-1:0] CNT_FULL = ccld_pkg::CNT_W'(ccld_pkg::TRAILER);
  localparam logic [ccld_pkg::EXT_W-1:0] EXT_TRL  = ccld_pkg::EXT_W'(ccld_pkg::TRAILER);

  logic [ccld_pkg::CNT_W-1:0] count_r;
  logic [ccld_pkg::CNT_W-1:0] count_nxt;
  logic [15:0]                crc_r;
  logic [15:0]                crc_nxt;
  logic                       dollar_r;
  logic                       dollar_nxt;

  // Trailer window, entry 0 the oldest; never read before a line has filled it.
  logic [7:0]                 win_byte_r  [ccld_pkg::WIN_LEN];
  logic                       win_star_r  [ccld_pkg::WIN_LEN];
  logic                       win_hexok_r [ccld_pkg::WIN_LEN];
  logic [3:0]                 win_hex_r   [ccld_pkg::WIN_LEN];
  logic                       shift_en;

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       out_is_end_r;
  logic [7:0]                 out_data_r;
  logic [1:0]                 out_status_r;
  logic [8:0]                 out_len_r;

  logic                       pop;
  logic                       res_valid;
  logic                       res_end;
  logic [7:0]                 res_data;
  ccld_pkg::status_t          res_status;
  logic [8:0]                 res_len;
  logic [ccld_pkg::EXT_W-1:0] len_ext;
  logic                       malformed;
  logic [15:0]                rx_crc;

  // The engine takes a beat only when the result register has room for what it may give.
  assign tok_ready = !out_valid_r || out_ready;
  assign pop       = tok_valid && tok_ready;

  assign rx_crc    = {win_hex_r[1], win_hex_r[2], win_hex_r[3], win_hex_r[4]};
  assign malformed = !dollar_r || (count_r < CNT_MIN) || !win_star_r[0] ||
                     !(win_hexok_r[1] && win_hexok_r[2] && win_hexok_r[3] && win_hexok_r[4]);
  assign len_ext   = ccld_pkg::EXT_W'(count_r) - EXT_TRL;

  always_comb begin
    count_nxt  = count_r;
    crc_nxt    = crc_r;
    dollar_nxt = dollar_r;
    shift_en   = 1'b0;
    res_valid  = 1'b0;
    res_end    = 1'b0;
    res_data   = 8'h00;
    res_status = ccld_pkg::ST_GOOD;
    res_len    = '0;
    if (pop) begin
      if (tok.kind == ccld_pkg::TK_EOL) begin
        if (count_r != '0) begin
          res_valid = 1'b1;
          res_end   = 1'b1;
          if (malformed) begin
            res_status = ccld_pkg::ST_MALFORMED;
          end else if (rx_crc != crc_r) begin
            res_status = ccld_pkg::ST_CRC_BAD;
          end else begin
            res_len = len_ext[8:0];
          end
          count_nxt  = '0;
          crc_nxt    = ccld_pkg::CRC_INIT;
          dollar_nxt = 1'b0;
        end
      end else if (count_r == CNT_MAX) begin
        // The byte that would fill the line buffer is dropped with the line.
        res_valid  = 1'b1;
        res_end    = 1'b1;
        res_status = ccld_pkg::ST_OVERFLOW;
        count_nxt  = '0;
        crc_nxt    = ccld_pkg::CRC_INIT;
        dollar_nxt = 1'b0;
      end else if (count_r == '0) begin
        dollar_nxt = tok.is_dollar;
        count_nxt  = ccld_pkg::CNT_W'(1);
      end else begin
        if (count_r >= CNT_FULL) begin
          res_valid = 1'b1;
          res_data  = win_byte_r[0];
          crc_nxt   = ccld_pkg::crc_feed(crc_r, win_byte_r[0]);
        end
        shift_en  = 1'b1;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      crc_r       <= ccld_pkg::CRC_INIT;
      dollar_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      crc_r       <= crc_nxt;
      dollar_r    <= dollar_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int k = 0; k < ccld_pkg::WIN_LEN - 1; k++) begin
        win_byte_r[k]  <= win_byte_r[k+1];
        win_star_r[k]  <= win_star_r[k+1];
        win_hexok_r[k] <= win_hexok_r[k+1];
        win_hex_r[k]   <= win_hex_r[k+1];
      end
      win_byte_r[ccld_pkg::WIN_LEN-1]  <= tok.data;
      win_star_r[ccld_pkg::WIN_LEN-1]  <= tok.is_star;
      win_hexok_r[ccld_pkg::WIN_LEN-1] <= tok.hex_ok;
      win_hex_r[ccld_pkg::WIN_LEN-1]   <= tok.hex_val;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_is_end_r <= res_end;
      out_data_r   <= res_data;
      out_status_r <= res_status;
      out_len_r    <= res_len;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_end         = out_is_end_r;
  assign out_data_byte      = out_data_r;
  assign out_status         = out_status_r;
  assign out_payload_length = out_len_r;

  a_clear_after_end : assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_end) |=> (count_r == '0 && crc_r == ccld_pkg::CRC_INIT && !dollar_r))
    else $error("line state not cleared after a status result");

  a_payload_full_win : assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_end) |-> (count_r >= CNT_FULL))
    else $error("payload byte given before the trailer window filled");

  a_no_clobber : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !pop)
    else $error("beat taken while a result is still held");

  a_crc_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r < CNT_FULL) |-> (crc_r == ccld_pkg::CRC_INIT))
    else $error("CRC moved before any payload byte");

endmodule

`default_nettype wire

// ===== rtl/crc_checked_line_deframer.sv =====
// Top level of the CRC-checked '$payload*HHHH' line deframer.
`default_nettype none

// Takes one received byte per beat and gives at most one result per byte: a payload
// byte (is_end low) once it has left the five-byte trailer window, or a status beat
// (is_end high) when a line feed ends a non-empty line or the line would reach
// LINE_BYTES bytes. Carriage returns are swallowed. Payload bytes are released before
// the line is checked; the status beat says whether they formed a good payload, and
// only a good line carries a non-zero payload_length. The block sustains one byte per
// clock cycle while out_ready stays high. A byte is registered first in the classifier
// register and then in the two-entry queue, from which the line engine pops it and
// loads its result register at the same edge. The engine's CRC-16-CCITT byte update
// and result register set that rate. Each side may stall on its own while the queue
// has room.
module crc_checked_line_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_is_end,
  output logic [7:0]      out_data_byte,
  output logic [1:0]      out_status,
  output logic [8:0]      out_payload_length
);

  logic           f_valid;
  logic           f_ready;
  ccld_pkg::tok_t f_tok;
  logic           q_valid;
  logic           q_ready;
  ccld_pkg::tok_t q_tok;

  ccld_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .tok_valid  (f_valid),
    .tok        (f_tok),
    .tok_ready  (f_ready)
  );

  ccld_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_tok   (f_tok),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_tok    (q_tok)
  );

  ccld_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .tok_valid          (q_valid),
    .tok_ready          (q_ready),
    .tok                (q_tok),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_is_end         (out_is_end),
    .out_data_byte      (out_data_byte),
    .out_status         (out_status),
    .out_payload_length (out_payload_length)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the CRC-checked line deframer: framed lines in, results checked.
`default_nettype none

module testbench;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 900;
  localparam int OVERFLOW_AT = 120;
  localparam int LONG_AT = 400;
  localparam int LONG_PAYLOAD = 256;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 150;
  localparam int DRAIN_CYCLES = 16;

  typedef enum int {FL_NONE, FL_HEADER, FL_STAR, FL_HEX, FL_CRC} flaw_t;
  typedef logic [7:0] bytes_t[$];

  typedef struct {
    logic              is_end;
    logic [7:0]        data;
    ccld_pkg::status_t status;
    logic [8:0]        plen;
  } deframe_res_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_is_end;
  logic [7:0] out_data_byte;
  logic [1:0] out_status;
  logic [8:0] out_payload_length;

  crc_checked_line_deframer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_end        (out_is_end),
    .out_data_byte     (out_data_byte),
    .out_status        (out_status),
    .out_payload_length(out_payload_length)
  );

  // Bytes still to be sent and beats still awaited.
  logic [7:0]   rx_stream[$];
  deframe_res_t expected_beats[$];
  int           total_bytes;
  int           n_accepted = 0;
  int           n_fail = 0;
  int           cycles = 0;

  // Shadow line state for the prediction.
  int          line_len = 0;
  logic [7:0]  tail[ccld_pkg::WIN_LEN];
  logic [15:0] crc_acc = ccld_pkg::CRC_INIT;
  bit          hdr_ok = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic put_byte(input logic [7:0] b);
    rx_stream.insert(rx_stream.size(), b);
  endtask

  task automatic put_expected(input deframe_res_t r);
    expected_beats.insert(expected_beats.size(), r);
  endtask

  // Bit-serial CRC-16-CCITT, most significant bit first.
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    int          i;
    c = acc;
    for (i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ ccld_pkg::CRC_POLY;
    end
    return c;
  endfunction

  function automatic bit hex_nibble(input logic [7:0] ch, output logic [3:0] v);
    v = 4'h0;
    if (ch >= 8'h30 && ch <= 8'h39) v = 4'(ch - 8'h30);
    else if (ch >= 8'h41 && ch <= 8'h46) v = 4'(ch - 8'h41 + 8'd10);
    else if (ch >= 8'h61 && ch <= 8'h66) v = 4'(ch - 8'h61 + 8'd10);
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      calm = $urandom_range(40, 160);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic bytes_t rand_payload(input int n);
    bytes_t     q;
    logic [7:0] ch;
    int         i;
    for (i = 0; i < n; i++) begin
      do ch = 8'($urandom_range(0, 255));
      while (ch == ccld_pkg::CH_CR || ch == ccld_pkg::CH_LF);
      q.insert(q.size(), ch);
    end
    return q;
  endfunction

  task automatic clear_line();
    line_len = 0;
    crc_acc = ccld_pkg::CRC_INIT;
    hdr_ok = 1'b0;
  endtask

  // Works out the beat, if any, that one accepted byte causes.
  task automatic deframe_predict(input logic [7:0] b);
    deframe_res_t      r;
    ccld_pkg::status_t st;
    logic [15:0]       rx_crc;
    logic [3:0]        nib;
    int                k;
    if (b == ccld_pkg::CH_CR) return;
    r.is_end = 1'b1;
    r.data = 8'h00;
    r.plen = 9'd0;
    if (b == ccld_pkg::CH_LF) begin
      if (line_len == 0) return;
      st = ccld_pkg::ST_GOOD;
      rx_crc = 16'h0000;
      if (!hdr_ok || line_len < ccld_pkg::MIN_LINE || tail[0] != ccld_pkg::CH_STAR) begin
        st = ccld_pkg::ST_MALFORMED;
      end else begin
        for (k = 1; k < ccld_pkg::WIN_LEN; k++) begin
          if (!hex_nibble(tail[k], nib)) st = ccld_pkg::ST_MALFORMED;
          rx_crc = {rx_crc[11:0], nib};
        end
        if (st == ccld_pkg::ST_GOOD && rx_crc != crc_acc) st = ccld_pkg::ST_CRC_BAD;
      end
      r.status = st;
      if (st == ccld_pkg::ST_GOOD) r.plen = 9'(line_len - ccld_pkg::TRAILER);
      put_expected(r);
      clear_line();
      return;
    end
    if (line_len + 1 >= ccld_pkg::LINE_BYTES) begin
      r.status = ccld_pkg::ST_OVERFLOW;
      put_expected(r);
      clear_line();
      return;
    end
    if (line_len == 0) begin
      hdr_ok = (b == ccld_pkg::CH_DOLLAR);
      line_len = 1;
      return;
    end
    // The oldest window byte leaves as payload once the window is full.
    if (line_len >= ccld_pkg::TRAILER) begin
      crc_acc = crc16_step(crc_acc, tail[0]);
      r.is_end = 1'b0;
      r.data = tail[0];
      r.status = ccld_pkg::ST_GOOD;
      put_expected(r);
    end
    for (k = 0; k < ccld_pkg::WIN_LEN - 1; k++) tail[k] = tail[k + 1];
    tail[ccld_pkg::WIN_LEN - 1] = b;
    line_len++;
  endtask

  // Queues one '$payload*HHHH' line, optionally spoilt, with stray carriage returns.
  task automatic frame_line(input bytes_t pay, input flaw_t flaw);
    bytes_t      body;
    logic [15:0] c;
    logic [7:0]  ch;
    int          i;
    c = ccld_pkg::CRC_INIT;
    if (flaw == FL_HEADER) begin
      do ch = 8'($urandom_range(0, 255));
      while (ch == ccld_pkg::CH_DOLLAR || ch == ccld_pkg::CH_CR || ch == ccld_pkg::CH_LF);
      body.insert(body.size(), ch);
    end else begin
      body.insert(body.size(), ccld_pkg::CH_DOLLAR);
    end
    for (i = 0; i < pay.size(); i++) begin
      body.insert(body.size(), pay[i]);
      c = crc16_step(c, pay[i]);
    end
    if (flaw == FL_CRC) c = c ^ (16'h0001 << $urandom_range(0, 15));
    if (flaw == FL_STAR) begin
      do ch = 8'($urandom_range(0, 255));
      while (ch == ccld_pkg::CH_STAR || ch == ccld_pkg::CH_CR || ch == ccld_pkg::CH_LF);
      body.insert(body.size(), ch);
    end else begin
      body.insert(body.size(), ccld_pkg::CH_STAR);
    end
    for (i = 3; i >= 0; i--) begin
      body.insert(body.size(), hex_char(c[4*i +: 4], 1'($urandom_range(0, 1))));
    end
    if (flaw == FL_HEX) begin
      // Characters just outside the digit ranges, plus sign, space and 0x forms.
      case ($urandom_range(0, 8))
        0: ch = 8'h2F;
        1: ch = 8'h3A;
        2: ch = 8'h40;
        3: ch = 8'h47;
        4: ch = 8'h60;
        5: ch = 8'h67;
        6: ch = 8'h20;
        7: ch = 8'h2B;
        default: ch = 8'h78;
      endcase
      body[body.size() - 1 - $urandom_range(0, 3)] = ch;
    end
    for (i = 0; i < body.size(); i++) begin
      if ($urandom_range(0, 31) == 0) put_byte(ccld_pkg::CH_CR);
      put_byte(body[i]);
    end
    if ($urandom_range(0, 1) == 1) put_byte(ccld_pkg::CH_CR);
    put_byte(ccld_pkg::CH_LF);
  endtask

  // Sender.
  int send_gap = 0;
  int send_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rx_byte <= 8'h00;
    end else begin
      if (in_valid && in_ready) begin
        deframe_predict(in_rx_byte);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (rx_stream.size() > 0) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_stream.pop_front();
          send_gap = idle_len(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker.
  int           recv_stall = 0;
  int           recv_calm = 0;
  int           hold_left = 0;
  bit           held_once = 1'b0;
  int           n_out = 0;
  deframe_res_t head;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_out++;
        if (expected_beats.size() == 0) begin
          $error("result beat with none expected: is_end=%0d data=%02h status=%0d length=%0d",
                 out_is_end, out_data_byte, out_status, out_payload_length);
          n_fail++;
        end else begin
          head = expected_beats.pop_front();
          if (out_is_end !== head.is_end) begin
            $error("is_end: expected %0d, got %0d", head.is_end, out_is_end);
            n_fail++;
          end
          if (out_data_byte !== head.data) begin
            $error("data_byte: expected %02h, got %02h", head.data, out_data_byte);
            n_fail++;
          end
          if (out_status !== head.status) begin
            $error("status: expected %0d, got %0d", head.status, out_status);
            n_fail++;
          end
          if (out_payload_length !== head.plen) begin
            $error("payload_length: expected %0d, got %0d", head.plen, out_payload_length);
            n_fail++;
          end
        end
      end
      // One long hold-off lets the block fill up and push back on its input.
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_once && n_out >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_stall = idle_len(recv_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  int         r;
  int         i;
  bit         overflow_done = 1'b0;
  bit         long_done = 1'b0;
  bytes_t     pay;
  logic [7:0] ch;

  initial begin
    // Directed lines: empty lines, a lone header, short lines, the shortest good line,
    // byte extremes in the payload and each way a line can be spoilt.
    put_byte(ccld_pkg::CH_LF);
    put_byte(ccld_pkg::CH_CR);
    put_byte(ccld_pkg::CH_LF);
    put_byte(ccld_pkg::CH_DOLLAR);
    put_byte(ccld_pkg::CH_LF);
    frame_line(rand_payload(0), FL_NONE);
    frame_line(rand_payload(1), FL_NONE);
    frame_line(rand_payload(2), FL_NONE);
    pay = '{8'h00, 8'hFF, 8'h7F, 8'h80};
    frame_line(pay, FL_NONE);
    frame_line(rand_payload(3), FL_HEADER);
    frame_line(rand_payload(3), FL_STAR);
    frame_line(rand_payload(3), FL_HEX);
    frame_line(rand_payload(3), FL_CRC);

    while (rx_stream.size() < ITEM_TARGET) begin
      if (!overflow_done && rx_stream.size() > OVERFLOW_AT) begin
        // A line that runs into the limit; the byte that hits it is dropped and a
        // good line follows straight after.
        overflow_done = 1'b1;
        pay = rand_payload(ccld_pkg::LINE_BYTES - 2);
        put_byte(ccld_pkg::CH_DOLLAR);
        for (i = 0; i < pay.size(); i++) put_byte(pay[i]);
        do ch = 8'($urandom_range(0, 255));
        while (ch == ccld_pkg::CH_CR || ch == ccld_pkg::CH_LF);
        put_byte(ch);
        frame_line(rand_payload($urandom_range(2, 12)), FL_NONE);
      end else if (!long_done && rx_stream.size() > LONG_AT) begin
        // A long good line whose payload length needs the top bit of the field.
        long_done = 1'b1;
        frame_line(rand_payload(LONG_PAYLOAD + $urandom_range(0, 8)), FL_NONE);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          frame_line(rand_payload($urandom_range(0, 9) == 0 ? $urandom_range(20, 60)
                                                            : $urandom_range(2, 16)),
                     FL_NONE);
        end else if (r < 75) begin
          frame_line(rand_payload($urandom_range(2, 12)), flaw_t'($urandom_range(1, 4)));
        end else if (r < 84) begin
          frame_line(rand_payload($urandom_range(0, 1)), FL_NONE);
        end else if (r < 93) begin
          for (i = $urandom_range(1, 20); i > 0; i--) put_byte(8'($urandom_range(0, 255)));
          put_byte(ccld_pkg::CH_LF);
        end else begin
          if ($urandom_range(0, 1) == 1) put_byte(ccld_pkg::CH_CR);
          put_byte(ccld_pkg::CH_LF);
        end
      end
    end
    total_bytes = rx_stream.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < total_bytes) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== crc_checked_line_deframer.f =====
rtl/ccld_pkg.sv
rtl/ccld_front.sv
rtl/ccld_queue.sv
rtl/ccld_back.sv
rtl/crc_checked_line_deframer.sv
bench/testbench.sv
